// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker modules of this project.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

// ===== src/i2cmon_pkg.sv =====
// Shared types and constants of the I2C bus monitor.
// No dependencies; used by the decoder, the event queue and the top level.
package i2cmon_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_USED_W  = 41;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef enum logic [2:0] {
    EV_IRQ_RISE = 3'd0,
    EV_IRQ_FALL = 3'd1,
    EV_START    = 3'd2,
    EV_STOP     = 3'd3,
    EV_ACK      = 3'd4,
    EV_NACK     = 3'd5
  } event_kind_e;

  // The data byte, the interrupt level and the time sit in the same order as
  // on the output tdata; the kind leaves on tuser and the last flag on tlast.
  typedef struct packed {
    logic        last;
    logic [31:0] ev_time;
    logic        irq_value;
    logic [7:0]  data_byte;
    event_kind_e kind;
  } event_t;

  // Events produced by one sample, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    event_t     first;
    event_t     second;
  } push_t;

endpackage

// ===== src/i2cmon_decode.sv =====
// Edge detection and frame decoding for the I2C bus monitor.
// Holds the bus state registers; depends on i2cmon_pkg.
module i2cmon_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_vld_i,
  input  logic               sda_i,
  input  logic               scl_i,
  input  logic               irq_i,
  input  logic [31:0]        ts_i,
  output i2cmon_pkg::push_t  push_o
);
  import i2cmon_pkg::*;

  logic                 primed_q, primed_d;
  logic                 prev_sda_q, prev_scl_q, prev_irq_q;
  logic                 in_frame_q, in_frame_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [7:0]           shift_q, shift_d;

  logic        irq_ev, bus_ev;
  event_kind_e bus_kind;
  logic [7:0]  bus_data;
  logic        scl_rise, scl_high_steady, sda_rise, sda_fall;
  event_t      irq_event, bus_event;

  assign scl_rise        = scl_i & ~prev_scl_q;
  assign scl_high_steady = scl_i & prev_scl_q;
  assign sda_rise        = sda_i & ~prev_sda_q;
  assign sda_fall        = ~sda_i & prev_sda_q;
  assign irq_ev          = primed_q & (irq_i != prev_irq_q);

  always_comb begin
    primed_d   = 1'b1;
    in_frame_d = in_frame_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    bus_ev     = 1'b0;
    bus_kind   = EV_STOP;
    bus_data   = 8'd0;
    if (primed_q) begin
      if (scl_rise) begin
        if (in_frame_q) begin
          if (bit_idx_q < BIT_IDX_W'(BITS_PER_BYTE)) begin
            shift_d   = {shift_q[6:0], sda_i};
            bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
          end else begin
            // Ninth clock: acknowledge slot closes the byte.
            bus_ev    = 1'b1;
            bus_kind  = sda_i ? EV_NACK : EV_ACK;
            bus_data  = shift_q;
            bit_idx_d = '0;
            shift_d   = 8'd0;
          end
        end
      end else if (scl_high_steady) begin
        if (sda_rise) begin
          bus_ev     = 1'b1;
          bus_kind   = EV_STOP;
          in_frame_d = 1'b0;
          bit_idx_d  = '0;
          shift_d    = 8'd0;
        end else if (sda_fall) begin
          bus_ev     = 1'b1;
          bus_kind   = EV_START;
          in_frame_d = 1'b1;
          bit_idx_d  = '0;
          shift_d    = 8'd0;
        end
      end
    end
  end

  always_comb begin
    irq_event.kind      = irq_i ? EV_IRQ_RISE : EV_IRQ_FALL;
    irq_event.data_byte = 8'd0;
    irq_event.irq_value = irq_i;
    irq_event.ev_time   = ts_i;
    irq_event.last      = ~bus_ev;

    bus_event.kind      = bus_kind;
    bus_event.data_byte = bus_data;
    bus_event.irq_value = irq_i;
    bus_event.ev_time   = ts_i;
    bus_event.last      = 1'b1;

    push_o.cnt    = sample_vld_i ? ({1'b0, irq_ev} + {1'b0, bus_ev}) : 2'd0;
    push_o.first  = irq_ev ? irq_event : bus_event;
    push_o.second = bus_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      prev_sda_q <= 1'b0;
      prev_scl_q <= 1'b0;
      prev_irq_q <= 1'b0;
      in_frame_q <= 1'b0;
      bit_idx_q  <= '0;
      shift_q    <= 8'd0;
    end else if (sample_vld_i) begin
      primed_q   <= primed_d;
      prev_sda_q <= sda_i;
      prev_scl_q <= scl_i;
      prev_irq_q <= irq_i;
      in_frame_q <= in_frame_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
    end
  end

endmodule

// ===== src/i2cmon_evq.sv =====
// Small event queue of the I2C bus monitor: takes up to two events a cycle
// and delivers one a cycle while the output takes them. Depends on i2cmon_pkg.
module i2cmon_evq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2cmon_pkg::push_t  push_i,
  input  logic               pop_i,
  output logic               space_o,
  output logic               head_vld_o,
  output i2cmon_pkg::event_t head_o
);
  import i2cmon_pkg::*;

  event_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_pop;
  logic [QPTR_W-1:0]   wr_next;

  assign do_pop     = pop_i & head_vld_o;
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = entry_q[rd_q];
  assign wr_next    = wr_q + QPTR_W'(1);
  // Room for the worst case of two events from the next sample.
  assign space_o    = (cnt_q <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.cnt[QPTR_W-1:0];
      rd_q  <= rd_q + QPTR_W'(do_pop);
      cnt_q <= cnt_q + QCNT_W'(push_i.cnt) - QCNT_W'(do_pop);
    end
  end

endmodule

// ===== src/i2c_bus_monitor.sv =====
// Passive I2C bus monitor. Every input request is one sample of SDA, SCL and
// an interrupt line with a 32-bit timestamp; a new sample can be taken in
// every cycle while tready is high. The sample is decoded in the same cycle
// it is accepted, and its first event can be offered on the output from the
// next cycle on: an interrupt edge gives a rising or falling event,
// an SDA fall or rise with SCL held high gives a start or a stop, and inside
// a frame each SCL rise shifts in one SDA bit, most significant first, the
// ninth rise giving an ACK or NACK data event with the byte. The very first
// sample after reset only loads the edge detectors. One sample yields zero,
// one or two events; they go into a four-entry queue and leave one per cycle
// on the output stream while it takes them, the event kind on tuser and the
// final event of each sample marked by tlast. The output delivers at most
// one event per cycle, so a burst of samples with two events each backs up
// the queue and the input then pauses until it drains to two entries; samples
// with at most one event pass at full rate while the output flows and the
// queue holds two or less. Input tready is high whenever the queue has room
// for two more events. Depends on i2cmon_pkg, i2cmon_decode and i2cmon_evq.
module i2c_bus_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] sda_level, [1] scl_level, [2] irq_level, [34:3] timestamp, [39:35] zero
  input  logic [i2cmon_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [8] irq_value, [40:9] event_time, [47:41] zero
  output logic [i2cmon_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [2:0] event_kind
  output logic [2:0]  m_axis_tuser_o,
  // last_event
  output logic        m_axis_tlast_o
);
  import i2cmon_pkg::*;

  logic   sample_vld;
  push_t  push;
  event_t head;

  // A request is taken exactly when the queue can absorb its worst case.
  assign sample_vld = s_axis_tvalid_i & s_axis_tready_o;

  i2cmon_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_vld_i (sample_vld),
    .sda_i        (s_axis_tdata_i[0]),
    .scl_i        (s_axis_tdata_i[1]),
    .irq_i        (s_axis_tdata_i[2]),
    .ts_i         (s_axis_tdata_i[34:3]),
    .push_o       (push)
  );

  // The queue entries act as the result register; its head is shown directly.
  i2cmon_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (m_axis_tready_i),
    .space_o    (s_axis_tready_o),
    .head_vld_o (m_axis_tvalid_o),
    .head_o     (head)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                           head.ev_time, head.irq_value, head.data_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

// ===== src/i2cmon_checker.sv =====
// Port-level checker for the I2C bus monitor, bound to the top level.
// Depends on assert_macros.svh, i2cmon_pkg and the i2c_bus_monitor ports.
`include "assert_macros.svh"

module i2cmon_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [i2cmon_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [2:0]                         m_axis_tuser_o,
  input logic                               m_axis_tlast_o
);
  import i2cmon_pkg::*;

  logic                   out_stall;
  logic                   out_is_irq;
  logic                   out_is_data;
  logic [2:0]             out_kind;
  logic [7:0]             out_byte;
  logic                   out_irq;
  logic [OUT_TDATA_W+3:0] out_word;

  assign out_kind    = m_axis_tuser_o;
  assign out_byte    = m_axis_tdata_o[7:0];
  assign out_irq     = m_axis_tdata_o[8];
  assign out_word    = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_is_irq  = (out_kind == EV_IRQ_RISE) || (out_kind == EV_IRQ_FALL);
  assign out_is_data = (out_kind == EV_ACK) || (out_kind == EV_NACK);

  // A stalled event must be held unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // Only data events carry a byte.
  `ASSERT_IMPLIES(a_byte_only_data, clk_i, rst_ni, m_axis_tvalid_o && !out_is_data, out_byte == 8'd0)

  // An interrupt event reports the level that its kind names.
  `ASSERT_IMPLIES(a_irq_level, clk_i, rst_ni, m_axis_tvalid_o && out_is_irq, out_irq == (out_kind == EV_IRQ_RISE))

  // A bus event always closes its sample, so it is never followed by a second event.
  `ASSERT_IMPLIES(a_bus_last, clk_i, rst_ni, m_axis_tvalid_o && !out_is_irq, m_axis_tlast_o)

  // The input only pauses while events are waiting to leave.
  `ASSERT_IMPLIES(a_pause_has_event, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o)

endmodule

bind i2c_bus_monitor i2cmon_checker u_i2cmon_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/sv/i2cmon_tb_pkg.sv =====
// Event tracker for the I2C bus monitor testbench: predicts the events of
// every accepted sample and checks the events that leave the block.
// Depends on i2cmon_pkg for the event kinds, the event record and widths.
package i2cmon_tb_pkg;

  import i2cmon_pkg::*;

  class i2c_event_tracker;

    // Decoder state, mirrored from the block.
    bit                   primed;
    bit                   prev_sda;
    bit                   prev_scl;
    bit                   prev_irq;
    bit                   in_frame;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [7:0]           shift_byte;

    // Events predicted but not yet seen on the output, oldest first.
    event_t               pending_events[$];
    int unsigned          mismatches;

    function new();
      primed     = 1'b0;
      prev_sda   = 1'b0;
      prev_scl   = 1'b0;
      prev_irq   = 1'b0;
      in_frame   = 1'b0;
      bit_index  = '0;
      shift_byte = '0;
      mismatches = 0;
    endfunction

    function void queue_event(event_kind_e kind, logic [7:0] byte_val, logic irq,
                              logic [31:0] ts);
      event_t ev;
      ev.kind      = kind;
      ev.data_byte = byte_val;
      ev.irq_value = irq;
      ev.ev_time   = ts;
      ev.last      = 1'b0;
      pending_events.push_back(ev);
    endfunction

    // Called for every accepted input request.
    function void note_sample(logic [IN_TDATA_W-1:0] d);
      logic        sda;
      logic        scl;
      logic        irq;
      logic [31:0] ts;
      bit          sda_rise;
      bit          sda_fall;
      bit          scl_rise;
      bit          scl_steady;
      int          base_cnt;
      sda = d[0];
      scl = d[1];
      irq = d[2];
      ts  = d[34:3];
      if (!primed) begin
        primed   = 1'b1;
        prev_sda = sda;
        prev_scl = scl;
        prev_irq = irq;
        return;
      end
      base_cnt   = pending_events.size();
      sda_rise   = (sda != prev_sda) && sda;
      sda_fall   = (sda != prev_sda) && !sda;
      scl_rise   = (scl != prev_scl) && scl;
      scl_steady = (scl == prev_scl);
      prev_sda   = sda;
      prev_scl   = scl;

      if (irq != prev_irq) begin
        prev_irq = irq;
        queue_event(irq ? EV_IRQ_RISE : EV_IRQ_FALL, 8'h00, irq, ts);
      end

      if (scl_rise) begin
        if (in_frame) begin
          if (bit_index < BITS_PER_BYTE) begin
            shift_byte = {shift_byte[6:0], sda};
            bit_index  = bit_index + 1'b1;
          end else begin
            queue_event(sda ? EV_NACK : EV_ACK, shift_byte, irq, ts);
            bit_index  = '0;
            shift_byte = '0;
          end
        end
      end else if (scl_steady && scl) begin
        if (sda_rise) begin
          in_frame   = 1'b0;
          bit_index  = '0;
          shift_byte = '0;
          queue_event(EV_STOP, 8'h00, irq, ts);
        end else if (sda_fall) begin
          in_frame   = 1'b1;
          bit_index  = '0;
          shift_byte = '0;
          queue_event(EV_START, 8'h00, irq, ts);
        end
      end

      if (pending_events.size() > base_cnt) begin
        pending_events[pending_events.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
      $display("%0t event check: %s got 0x%0h want 0x%0h", $time, field, got, want);
      mismatches++;
    endtask

    // Called for every accepted output request.
    task check_event(logic [OUT_TDATA_W-1:0] d, logic [2:0] kind, logic last);
      event_t want;
      if (pending_events.size() == 0) begin
        report("event with nothing pending", d, 0);
        return;
      end
      want = pending_events.pop_front();
      if (kind !== want.kind) begin
        report("event_kind", kind, want.kind);
      end
      if (d[7:0] !== want.data_byte) begin
        report("data_byte", d[7:0], want.data_byte);
      end
      if (d[8] !== want.irq_value) begin
        report("irq_value", d[8], want.irq_value);
      end
      if (d[40:9] !== want.ev_time) begin
        report("event_time", d[40:9], want.ev_time);
      end
      if (d[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
        report("tdata padding", d[OUT_TDATA_W-1:OUT_USED_W], 0);
      end
      if (last !== want.last) begin
        report("tlast", last, want.last);
      end
    endtask

  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top of the I2C bus monitor testbench: drives sample streams, directed and
// random, with bursty input and a stalling output, and checks every event.
// Depends on i2cmon_pkg, i2cmon_tb_pkg and the i2c_bus_monitor RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmon_pkg::*;
  import i2cmon_tb_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned FLOOD_ITEMS  = 40;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0]             m_tuser;
  logic                   m_tlast;

  i2c_event_tracker tracker = new();

  // Samples waiting to be offered, and the bus levels they leave behind.
  logic [IN_TDATA_W-1:0] sample_q[$];
  bit                    cur_sda;
  bit                    cur_scl;
  bit                    cur_irq;
  int unsigned           items_sent;
  int unsigned           burst_left;

  // Set by the stimulus to make the event sink hold off for a long stretch.
  bit                    hold_off_req;

  i2c_bus_monitor dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Appends one sample with explicit levels and timestamp.
  function automatic void push_sample(bit sda, bit scl, bit irq, logic [31:0] ts);
    sample_q.push_back({{(IN_TDATA_W - 35){1'b0}}, ts, irq, scl, sda});
    cur_sda = sda;
    cur_scl = scl;
    cur_irq = irq;
  endfunction

  // Appends one bus sample; the interrupt line toggles now and then, and the
  // timestamp is random with its extremes showing up from time to time.
  function automatic void bus_sample(bit sda, bit scl);
    logic [31:0] ts;
    bit          irq;
    irq = cur_irq;
    if ($urandom_range(0, 7) == 0) begin
      irq = ~irq;
    end
    case ($urandom_range(0, 31))
      0:       ts = 32'h0000_0000;
      1:       ts = 32'hFFFF_FFFF;
      default: ts = $urandom();
    endcase
    push_sample(sda, scl, irq, ts);
  endfunction

  // Start condition: SCL low, SDA high, SCL high, then SDA falls. Works as a
  // repeated start from inside a frame as well.
  function automatic void gen_start();
    if (cur_scl) begin
      bus_sample(cur_sda, 1'b0);
    end
    bus_sample(1'b1, 1'b0);
    bus_sample(1'b1, 1'b1);
    bus_sample(1'b0, 1'b1);
  endfunction

  // Stop condition: SDA low while SCL is low, SCL high, then SDA rises.
  function automatic void gen_stop();
    if (cur_scl) begin
      bus_sample(cur_sda, 1'b0);
    end
    bus_sample(1'b0, 1'b0);
    bus_sample(1'b0, 1'b1);
    bus_sample(1'b1, 1'b1);
  endfunction

  // One bit cell. Sometimes the SDA change rides on the SCL fall itself,
  // sometimes the high phase of SCL lasts two samples.
  function automatic void gen_bit(bit b);
    if (cur_scl && $urandom_range(0, 1) == 0) begin
      bus_sample(cur_sda, 1'b0);
    end
    bus_sample(b, 1'b0);
    bus_sample(b, 1'b1);
    if ($urandom_range(0, 2) == 0) begin
      bus_sample(b, 1'b1);
    end
  endfunction

  // Eight data bits, most significant first, then the acknowledge bit.
  function automatic void gen_byte(logic [7:0] value, bit nack);
    for (int i = 7; i >= 0; i--) begin
      gen_bit(value[i]);
    end
    gen_bit(nack);
  endfunction

  // Offers every queued sample. In bursty mode the sender works in bursts of
  // random length separated by random gaps; otherwise it never lets go of
  // tvalid, which is how the flood phase keeps the input side pressed.
  task automatic send_queue(input bit bursty);
    logic [IN_TDATA_W-1:0] d;
    int unsigned           gap;
    while (sample_q.size() != 0) begin
      if (bursty && burst_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      d = sample_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= d;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      // The request was taken at this edge.
      tracker.note_sample(d);
      items_sent++;
      if (burst_left != 0) begin
        burst_left--;
      end
    end
  endtask

  // Lets go of the input and waits until every predicted event has come out.
  // It waits on the clock before the first check, so tvalid is never lowered
  // and raised again in the same time step.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_events.size() != 0) @(posedge clk);
  endtask

  // Event sink. Checks every output request at the edge that takes it, and
  // drives tready on a stall pattern of its own: stretches of full flow,
  // coin-flip stalls and mostly stalled phases, plus the long hold-off the
  // stimulus asks for, counted here in cycles.
  initial begin : event_sink
    int unsigned stall_left;
    int unsigned pat_left;
    int unsigned pat_mode;
    stall_left = 0;
    pat_left   = 0;
    pat_mode   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        tracker.check_event(m_tdata, m_tuser, m_tlast);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 2);
          pat_left = $urandom_range(10, 150);
        end
        pat_left--;
        case (pat_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Cycle counter that ends a run that hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] dir_byte;
    int unsigned nbytes;
    int unsigned nbits;
    items_sent   = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    cur_sda      = 1'b1;
    cur_scl      = 1'b1;
    cur_irq      = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first sample only primes the edge detectors. The
    // second raises the interrupt line and drops SDA under a high SCL, so it
    // gives two events, with the timestamp at its largest value.
    push_sample(1'b1, 1'b1, 1'b0, 32'h0000_0000);
    push_sample(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // One byte with two samples per bit cell. The SDA change of each cell
    // rides on the SCL fall, which the decoder must absorb. The acknowledge
    // rise comes with an interrupt fall, again two events from one sample.
    dir_byte = 8'h96;
    for (int i = 7; i >= 0; i--) begin
      push_sample(dir_byte[i], 1'b0, 1'b1, $urandom());
      push_sample(dir_byte[i], 1'b1, 1'b1, $urandom());
    end
    push_sample(1'b1, 1'b0, 1'b1, $urandom());
    push_sample(1'b1, 1'b1, 1'b0, $urandom());
    // Stop, then an SCL pulse outside any frame, which must be ignored.
    push_sample(1'b0, 1'b0, 1'b0, $urandom());
    push_sample(1'b0, 1'b1, 1'b0, $urandom());
    push_sample(1'b1, 1'b1, 1'b0, $urandom());
    push_sample(1'b1, 1'b0, 1'b0, $urandom());
    push_sample(1'b1, 1'b1, 1'b0, $urandom());
    send_queue(1'b1);

    // Sender pause: nothing more is offered until every event is out.
    wait_drained();

    // Flood: every sample toggles the interrupt and gives a start or a stop,
    // two events each, while the sink holds off. The queue fills and the
    // input must stall until the sink lets go.
    for (int i = 0; i < FLOOD_ITEMS; i++) begin
      push_sample(~cur_sda, 1'b1, ~cur_irq, $urandom());
    end
    hold_off_req = 1'b1;
    send_queue(1'b0);
    wait_drained();

    // Random part, mostly well-formed transfers with random content.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        7: begin
          // Line noise.
          repeat ($urandom_range(1, 8)) begin
            bus_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        8: begin
          // Transfer broken off in the middle of a byte.
          gen_start();
          nbits = $urandom_range(1, 8);
          repeat (nbits) gen_bit(1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1) == 0) begin
            gen_stop();
          end else begin
            gen_start();
          end
        end
        9: begin
          // Stops and SCL pulses outside a frame.
          gen_stop();
          repeat ($urandom_range(1, 3)) begin
            bus_sample(cur_sda, 1'b0);
            bus_sample(cur_sda, 1'b1);
          end
          gen_stop();
        end
        default: begin
          gen_start();
          nbytes = $urandom_range(1, 3);
          repeat (nbytes) begin
            gen_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          end
          // Without a stop the next transfer opens with a repeated start.
          if ($urandom_range(0, 3) != 0) begin
            gen_stop();
          end
        end
      endcase
      send_queue(1'b1);
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/i2cmon_pkg.sv
src/i2cmon_decode.sv
src/i2cmon_evq.sv
src/i2c_bus_monitor.sv
src/i2cmon_checker.sv
tb/sv/i2cmon_tb_pkg.sv
tb/sv/tb_top.sv
